// File: sv/dss_pkg.sv
`timescale 1ns / 1ps

package dss_pkg;

    localparam int TIME_BITS = 16;
    localparam int FRAC_BITS = 16;
    localparam int MS_PER_S = 1000;
    localparam int COEF_SCALE = 16;
    localparam int DT_MAX_MS = 40;
    localparam int DT_W = $clog2(DT_MAX_MS + 1);

    localparam int POS_W = 32;
    localparam int K_W = 14;
    localparam int C_W = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DIFF_W = POS_W + 1;
    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = K_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W = MUL_A_W;

    localparam int DEN_VEL = MS_PER_S * COEF_SCALE;
    localparam int DEN_POS = MS_PER_S;
    localparam int NUM_W = 54;
    localparam int UPD_W = NUM_W + 2;

    // Both divisors are 125 shifted left, by 7 for 16000 and by 3 for 1000.
    localparam int DIV_ODD = 125;
    localparam int SHIFT_VEL = 7;
    localparam int SHIFT_POS = 3;
    localparam int DIG_W = 17;
    localparam int DIGITS = 3;
    localparam int SHN_W = DIG_W * DIGITS;
    localparam int REM_W = 7;
    localparam int PART_W = REM_W + DIG_W;
    localparam int PROD_W = 2 * PART_W;
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP = (1 << RECIP_SHIFT) / DIV_ODD + 1;
    localparam int CNT_W = $clog2(DIGITS);

    localparam logic [NUM_W-1:0] HALF_VEL = NUM_W'(DEN_VEL / 2);
    localparam logic [NUM_W-1:0] HALF_POS = NUM_W'(DEN_POS / 2);
    localparam int SETTLE_MAX = ((1 << FRAC_BITS) - 1) / MS_PER_S;

    localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_POS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUCED = 3'd4;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_K,
        ST_MUL_C,
        ST_MUL_F,
        ST_DIV_V,
        ST_MUL_P,
        ST_DIV_P,
        ST_POS,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             start;
        logic             pos_phase;
        logic [NUM_W-1:0] num;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } div_rsp_t;

endpackage

// File: sv/dss_in_if.sv
`timescale 1ns / 1ps

interface dss_in_if;
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic [dss_pkg::TIME_BITS-1:0]  now_ms;

    modport source (output valid, output cmd, output now_ms, input ready);
    modport sink (input valid, input cmd, input now_ms, output ready);
endinterface

// File: sv/dss_out_if.sv
`timescale 1ns / 1ps

interface dss_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [dss_pkg::POS_W-1:0]   position;
    logic                               finished;
    logic                               last;

    modport source (output valid, output position, output finished, output last,
                    input ready);
    modport sink (input valid, input position, input finished, input last,
                  output ready);
endinterface

// File: sv/damped_spring_step.sv
`timescale 1ns / 1ps

// Damped spring stepped with semi-implicit Euler in signed Q15.16.
// Items arrive on in_ch: cmd 0 starts an animation from start_position
// when none is running, cmd 1 is a time tick carrying now_ms. Results leave
// on out_ch as position, finished and last; last marks the final result of a tick.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while the block is idle, which the block does not enforce.
// A start command gives no result. A running tick uses the shared
// multiplier in ST_MUL_K, ST_MUL_C and ST_MUL_F, waits for the velocity
// scaling division, uses the multiplier again in ST_MUL_P, waits for the
// position scaling division and makes the settling test in ST_POS before
// its first result is offered. A reduced-motion tick offers its result on
// the next cycle.
// The block takes one item at a time; in_ch.ready is high only when it is
// idle. A result is held on out_ch until its transfer completes, so a
// stalled receiver simply holds the block; a settling tick gives two
// results back to back. Reset stops the block, clears position, velocity
// and time, and loads the default register values.
module damped_spring_step
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dss_pkg::CFG_DATA_W-1:0]    cfg_data,
    dss_in_if.sink                            in_ch,
    dss_out_if.source                         out_ch
);

    dss_pkg::state_t                       state_reg, state_next;
    logic [dss_pkg::K_W-1:0]               stiffness_reg;
    logic [dss_pkg::C_W-1:0]               damping_reg;
    logic signed [dss_pkg::POS_W-1:0]      start_pos_reg;
    logic signed [dss_pkg::POS_W-1:0]      target_reg;
    logic                                  reduced_reg;
    logic signed [dss_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic signed [dss_pkg::POS_W-1:0]      vel_reg, vel_next;
    logic [dss_pkg::TIME_BITS-1:0]         prev_time_reg, prev_time_next;
    logic                                  running_reg, running_next;
    logic [dss_pkg::DT_W-1:0]              dt_reg, dt_next;
    logic signed [dss_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic                                  neg_reg, neg_next;
    logic signed [dss_pkg::POS_W-1:0]      out_pos_reg, out_pos_next;
    logic                                  out_fin_reg, out_fin_next;
    logic                                  out_last_reg, out_last_next;

    logic signed [dss_pkg::DIFF_W-1:0]     diff;
    logic [dss_pkg::DIFF_W-1:0]            diff_mag;
    logic [dss_pkg::DIFF_W-1:0]            vel_mag;
    logic signed [dss_pkg::MUL_A_W-1:0]    mul_a;
    logic signed [dss_pkg::MUL_B_W-1:0]    mul_b;
    logic signed [dss_pkg::MUL_P_W-1:0]    mul_prod;
    logic [dss_pkg::MUL_P_W-1:0]           mul_mag;
    logic [dss_pkg::TIME_BITS-1:0]         elapsed;
    logic signed [dss_pkg::UPD_W-1:0]      upd_base;
    logic signed [dss_pkg::UPD_W-1:0]      upd_step;
    logic signed [dss_pkg::UPD_W-1:0]      upd_sum;
    logic signed [dss_pkg::POS_W-1:0]      upd_sat;
    logic                                  settled;
    dss_pkg::div_req_t                     div_req;
    dss_pkg::div_rsp_t                     div_rsp;

    dss_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign diff = dss_pkg::DIFF_W'(pos_reg) - dss_pkg::DIFF_W'(target_reg);
    assign diff_mag = diff[dss_pkg::DIFF_W-1] ? dss_pkg::DIFF_W'(-diff)
                                              : dss_pkg::DIFF_W'(diff);
    assign vel_mag = vel_reg[dss_pkg::POS_W-1] ? dss_pkg::DIFF_W'(-dss_pkg::DIFF_W'(vel_reg))
                                               : dss_pkg::DIFF_W'(vel_reg);
    assign settled = (diff_mag <= dss_pkg::DIFF_W'(dss_pkg::SETTLE_MAX))
                  && (vel_mag <= dss_pkg::DIFF_W'(dss_pkg::SETTLE_MAX));

    // The single multiplier is shared by the four products of a step.
    always_comb
    begin
        case (state_reg)
            dss_pkg::ST_MUL_K:
            begin
                mul_a = dss_pkg::MUL_A_W'(diff);
                mul_b = $signed({1'b0, stiffness_reg});
            end
            dss_pkg::ST_MUL_C:
            begin
                mul_a = dss_pkg::MUL_A_W'(vel_reg);
                mul_b = $signed({{(dss_pkg::MUL_B_W - dss_pkg::C_W){1'b0}}, damping_reg});
            end
            dss_pkg::ST_MUL_F:
            begin
                mul_a = acc_reg;
                mul_b = $signed({{(dss_pkg::MUL_B_W - dss_pkg::DT_W){1'b0}}, dt_reg});
            end
            default:
            begin
                mul_a = dss_pkg::MUL_A_W'(vel_reg);
                mul_b = $signed({{(dss_pkg::MUL_B_W - dss_pkg::DT_W){1'b0}}, dt_reg});
            end
        endcase
    end

    assign mul_prod = dss_pkg::MUL_P_W'(mul_a) * dss_pkg::MUL_P_W'(mul_b);
    assign mul_mag = mul_prod[dss_pkg::MUL_P_W-1] ? dss_pkg::MUL_P_W'(-mul_prod)
                                                  : dss_pkg::MUL_P_W'(mul_prod);

    assign elapsed = in_ch.now_ms - prev_time_reg;

    // Shared adder with saturation for the velocity and position updates.
    assign upd_base = (state_reg == dss_pkg::ST_DIV_V) ? dss_pkg::UPD_W'(vel_reg)
                                                       : dss_pkg::UPD_W'(pos_reg);
    assign upd_step = neg_reg ? -$signed({2'b00, div_rsp.quo}) : $signed({2'b00, div_rsp.quo});
    assign upd_sum = upd_base + upd_step;

    always_comb
    begin
        if (upd_sum[dss_pkg::UPD_W-1:dss_pkg::POS_W-1] == '0
            || upd_sum[dss_pkg::UPD_W-1:dss_pkg::POS_W-1] == '1)
        begin
            upd_sat = upd_sum[dss_pkg::POS_W-1:0];
        end
        else if (upd_sum[dss_pkg::UPD_W-1])
        begin
            upd_sat = {1'b1, {(dss_pkg::POS_W - 1){1'b0}}};
        end
        else
        begin
            upd_sat = {1'b0, {(dss_pkg::POS_W - 1){1'b1}}};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next = pos_reg;
        vel_next = vel_reg;
        prev_time_next = prev_time_reg;
        running_next = running_reg;
        dt_next = dt_reg;
        acc_next = acc_reg;
        neg_next = neg_reg;
        out_pos_next = out_pos_reg;
        out_fin_next = out_fin_reg;
        out_last_next = out_last_reg;
        div_req.start = 1'b0;
        div_req.pos_phase = 1'b0;
        div_req.num = mul_mag[dss_pkg::NUM_W-1:0] + dss_pkg::HALF_POS;
        case (state_reg)
            dss_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.cmd == dss_pkg::CMD_START)
                    begin
                        if (!running_reg)
                        begin
                            pos_next = start_pos_reg;
                            vel_next = '0;
                            prev_time_next = '0;
                            running_next = 1'b1;
                        end
                    end
                    else if (running_reg)
                    begin
                        if (reduced_reg)
                        begin
                            pos_next = target_reg;
                            vel_next = '0;
                            running_next = 1'b0;
                            out_pos_next = target_reg;
                            out_fin_next = 1'b1;
                            out_last_next = 1'b1;
                            state_next = dss_pkg::ST_EMIT;
                        end
                        else
                        begin
                            prev_time_next = in_ch.now_ms;
                            if (in_ch.now_ms < prev_time_reg)
                            begin
                                dt_next = '0;
                            end
                            else if (elapsed > dss_pkg::TIME_BITS'(dss_pkg::DT_MAX_MS))
                            begin
                                dt_next = dss_pkg::DT_W'(dss_pkg::DT_MAX_MS);
                            end
                            else
                            begin
                                dt_next = elapsed[dss_pkg::DT_W-1:0];
                            end
                            state_next = dss_pkg::ST_MUL_K;
                        end
                    end
                end
            end
            dss_pkg::ST_MUL_K:
            begin
                acc_next = mul_prod[dss_pkg::ACC_W-1:0];
                state_next = dss_pkg::ST_MUL_C;
            end
            dss_pkg::ST_MUL_C:
            begin
                acc_next = acc_reg + mul_prod[dss_pkg::ACC_W-1:0];
                state_next = dss_pkg::ST_MUL_F;
            end
            dss_pkg::ST_MUL_F:
            begin
                // The force is the negated sum, so the step sign flips.
                neg_next = !mul_prod[dss_pkg::MUL_P_W-1] && (mul_prod != '0);
                div_req.start = 1'b1;
                div_req.num = mul_mag[dss_pkg::NUM_W-1:0] + dss_pkg::HALF_VEL;
                state_next = dss_pkg::ST_DIV_V;
            end
            dss_pkg::ST_DIV_V:
            begin
                if (div_rsp.done)
                begin
                    vel_next = upd_sat;
                    state_next = dss_pkg::ST_MUL_P;
                end
            end
            dss_pkg::ST_MUL_P:
            begin
                neg_next = mul_prod[dss_pkg::MUL_P_W-1];
                div_req.start = 1'b1;
                div_req.pos_phase = 1'b1;
                state_next = dss_pkg::ST_DIV_P;
            end
            dss_pkg::ST_DIV_P:
            begin
                if (div_rsp.done)
                begin
                    pos_next = upd_sat;
                    state_next = dss_pkg::ST_POS;
                end
            end
            dss_pkg::ST_POS:
            begin
                out_pos_next = pos_reg;
                out_fin_next = 1'b0;
                out_last_next = !settled;
                if (settled)
                begin
                    pos_next = target_reg;
                    vel_next = '0;
                    running_next = 1'b0;
                end
                state_next = dss_pkg::ST_EMIT;
            end
            dss_pkg::ST_EMIT:
            begin
                if (out_ch.ready)
                begin
                    if (out_last_reg)
                    begin
                        state_next = dss_pkg::ST_IDLE;
                    end
                    else
                    begin
                        out_pos_next = target_reg;
                        out_fin_next = 1'b1;
                        out_last_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = dss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dss_pkg::ST_IDLE;
            stiffness_reg <= dss_pkg::K_W'(2880);
            damping_reg <= dss_pkg::C_W'(224);
            start_pos_reg <= '0;
            target_reg <= dss_pkg::POS_W'(65536);
            reduced_reg <= 1'b0;
            pos_reg <= '0;
            vel_reg <= '0;
            prev_time_reg <= '0;
            running_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg <= pos_next;
            vel_reg <= vel_next;
            prev_time_reg <= prev_time_next;
            running_reg <= running_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    dss_pkg::CFG_STIFFNESS:  stiffness_reg <= cfg_data[dss_pkg::K_W-1:0];
                    dss_pkg::CFG_DAMPING:    damping_reg <= cfg_data[dss_pkg::C_W-1:0];
                    dss_pkg::CFG_START_POS:  start_pos_reg <= cfg_data[dss_pkg::POS_W-1:0];
                    dss_pkg::CFG_TARGET_POS: target_reg <= cfg_data[dss_pkg::POS_W-1:0];
                    dss_pkg::CFG_REDUCED:    reduced_reg <= cfg_data[0];
                    default:                 reduced_reg <= reduced_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg <= dt_next;
        acc_reg <= acc_next;
        neg_reg <= neg_next;
        out_pos_reg <= out_pos_next;
        out_fin_reg <= out_fin_next;
        out_last_reg <= out_last_next;
    end

    assign in_ch.ready = (state_reg == dss_pkg::ST_IDLE);
    assign out_ch.valid = (state_reg == dss_pkg::ST_EMIT);
    assign out_ch.position = out_pos_reg;
    assign out_ch.finished = out_fin_reg;
    assign out_ch.last = out_last_reg;

`ifndef NO_ASSERTIONS
    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid)
        else $error("input taken while a result is pending");

    a_finished_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.finished) |-> out_ch.last)
        else $error("finished result not marked last");

    a_finished_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.finished) |=> !running_reg)
        else $error("block still running after finished transfer");

    a_start_clears_vel: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(running_reg) |-> (vel_reg == '0 && prev_time_reg == '0))
        else $error("start did not clear velocity and time");
`endif

endmodule

// File: sv/dss_div.sv
`timescale 1ns / 1ps

// Division by 16000 or by 1000. A shift removes the power of two, then the
// odd factor 125 is divided out one 17-bit digit per cycle by reciprocal
// multiplication, and a registered done flag marks the ready quotient.
module dss_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  dss_pkg::div_req_t req,
    output dss_pkg::div_rsp_t rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [dss_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [dss_pkg::REM_W-1:0]         rem_reg, rem_next;
    logic [dss_pkg::SHN_W-1:0]         quo_reg, quo_next;
    logic [dss_pkg::PART_W-1:0]        part;
    logic [dss_pkg::PROD_W-1:0]        recip_prod;
    logic [dss_pkg::DIG_W-1:0]         digit_quo;
    logic [dss_pkg::REM_W-1:0]         digit_rem;

    assign part = {rem_reg, quo_reg[dss_pkg::SHN_W-1 -: dss_pkg::DIG_W]};
    assign recip_prod = dss_pkg::PROD_W'(part) * dss_pkg::PROD_W'(dss_pkg::RECIP);
    assign digit_quo = recip_prod[dss_pkg::RECIP_SHIFT +: dss_pkg::DIG_W];
    assign digit_rem = part[dss_pkg::REM_W-1:0]
                     - dss_pkg::REM_W'(dss_pkg::PART_W'(digit_quo)
                                       * dss_pkg::PART_W'(dss_pkg::DIV_ODD));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next = dss_pkg::CNT_W'(dss_pkg::DIGITS - 1);
            rem_next = '0;
            quo_next = req.pos_phase ? dss_pkg::SHN_W'(req.num >> dss_pkg::SHIFT_POS)
                                     : dss_pkg::SHN_W'(req.num >> dss_pkg::SHIFT_VEL);
        end
        else if (busy_reg)
        begin
            rem_next = digit_rem;
            quo_next = {quo_reg[dss_pkg::SHN_W-dss_pkg::DIG_W-1:0], digit_quo};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo = dss_pkg::NUM_W'(quo_reg);

endmodule
